// ===== src/tsb_pkg.sv =====
// Package for the tile sprite blitter: payload structs, register indexes,
// sheet geometry and drawing constants. Depends on nothing.
`default_nettype none

package tsb_pkg;

  // Sheet geometry. The sheet store is addressed by a 16-bit word.
  localparam int SHEET_WIDTH    = 256;
  localparam int SHEET_DEPTH    = 65536;
  localparam int SHEET_AW       = 16;
  localparam int TILE_SIZE      = 8;
  localparam int TILES_PER_ROW  = 32;
  localparam int MAX_SCREEN_DIM = 1024;

  // Palette byte that marks a transparent pixel.
  localparam logic [7:0] TRANSPARENT = 8'hFF;

  // Bit positions inside mirror_bits.
  localparam int MIRROR_X = 0;
  localparam int MIRROR_Y = 1;

  // Request kinds.
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_DRAW = 1'b1;

  // Configuration register indexes.
  localparam logic [7:0] REG_SCROLL_X      = 8'd0;
  localparam logic [7:0] REG_SCROLL_Y      = 8'd1;
  localparam logic [7:0] REG_SCREEN_WIDTH  = 8'd2;
  localparam logic [7:0] REG_SCREEN_HEIGHT = 8'd3;

  // One input item.
  typedef struct packed {
    logic        req_type;
    logic [15:0] sheet_address;
    logic [1:0]  sheet_value;
    logic [15:0] x_pos;
    logic [15:0] y_pos;
    logic [9:0]  tile_index;
    logic [31:0] palette;
    logic [1:0]  mirror_bits;
  } req_t;

  // One framebuffer write command.
  typedef struct packed {
    logic [19:0] pixel_address;
    logic [7:0]  pixel_colour;
    logic        last_write;
  } pix_t;

endpackage

`default_nettype wire

// ===== src/tsb_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Used for the sprite sheet store; depends on nothing.
`default_nettype none

module tsb_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 65536
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port; the data holds while no read is enabled.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== src/tile_sprite_blitter.sv =====
// Tile sprite blitter top level: sequencer, pixel scan and output register.
// Depends on tsb_pkg and tsb_ram.
// A load item leaves the block idle, so loads can follow back to back. A draw item
// holds in_ready low through ST_SETUP and ST_BASE, the scan (one step per tile pixel,
// with up to 64 sheet reads through the single read port, then the read stage empties)
// and the drain state, and longer while the output side stalls. The next item is taken
// once in_ready returns, and the draw's last write, if it has one, shows on out_valid in
// the cycle in_ready returns. Synchronous reset restores the registers to their defaults
// (scroll 0, screen 160 by 120) and empties the pipeline; the sheet is not cleared.
`default_nettype none

module tile_sprite_blitter (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire tsb_pkg::req_t in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output tsb_pkg::pix_t      out_data,
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire logic [7:0]    cfg_index,
  input  wire logic [15:0]   cfg_data
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SETUP = 3'd1;
  localparam logic [2:0] ST_BASE  = 3'd2;
  localparam logic [2:0] ST_SCAN  = 3'd3;
  localparam logic [2:0] ST_DRAIN = 3'd4;

  localparam int SHEET_AW_W = tsb_pkg::SHEET_AW;

  logic [2:0] state;

  // Configuration registers.
  logic [15:0] scroll_x;
  logic [15:0] scroll_y;
  logic [10:0] screen_width;
  logic [10:0] screen_height;

  // Latched draw item and derived setup values.
  logic [15:0] x_pos;
  logic [15:0] y_pos;
  logic [9:0]  tile_index;
  logic [31:0] palette;
  logic [1:0]  mirror_bits;
  logic [17:0] ox;
  logic [17:0] oy;
  logic [10:0] w_eff;
  logic [10:0] h_eff;
  logic [15:0] toffs;
  logic [19:0] row_base;

  // Scan counter, read stage and pending result.
  logic [6:0]  cnt;
  logic        s1_full;
  logic        s1_inside;
  logic [19:0] s1_addr;
  logic        pend_valid;
  logic [19:0] pend_addr;
  logic [7:0]  pend_col;

  logic [2:0]  px;
  logic [2:0]  py;
  logic [2:0]  xs;
  logic [2:0]  ys;
  logic [17:0] sx;
  logic [17:0] sy;
  logic        on_screen;
  logic        issue;
  logic        stall;
  logic        move_ok;
  logic        vis;
  logic [1:0]  rd_data;
  logic [7:0]  col;
  logic [SHEET_AW_W-1:0] rd_addr;
  logic        load_wr;
  logic        in_xfer;

  assign in_ready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_xfer   = in_valid && in_ready;
  assign load_wr   = in_xfer && (in_data.req_type == tsb_pkg::REQ_LOAD);

  // Sheet store.
  tsb_ram #(
    .WIDTH(2),
    .DEPTH(tsb_pkg::SHEET_DEPTH)
  ) u_sheet (
    .clk    (clk),
    .wr_en  (load_wr),
    .wr_addr(in_data.sheet_address),
    .wr_data(in_data.sheet_value),
    .rd_en  (issue && on_screen),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      scroll_x      <= 16'd0;
      scroll_y      <= 16'd0;
      screen_width  <= 11'd160;
      screen_height <= 11'd120;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        tsb_pkg::REG_SCROLL_X:      scroll_x      <= cfg_data;
        tsb_pkg::REG_SCROLL_Y:      scroll_y      <= cfg_data;
        tsb_pkg::REG_SCREEN_WIDTH:  screen_width  <= cfg_data[10:0];
        tsb_pkg::REG_SCREEN_HEIGHT: screen_height <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  // Pixel position within the tile and its screen and sheet coordinates.
  assign px = cnt[2:0];
  assign py = cnt[5:3];
  assign xs = mirror_bits[tsb_pkg::MIRROR_X] ? ~px : px;
  assign ys = mirror_bits[tsb_pkg::MIRROR_Y] ? ~py : py;
  assign sx = ox + {15'd0, px};
  assign sy = oy + {15'd0, py};
  assign on_screen = !sx[17] && (sx < {7'd0, w_eff}) && !sy[17] && (sy < {7'd0, h_eff});
  assign rd_addr = toffs + SHEET_AW_W'(32'(ys) * tsb_pkg::SHEET_WIDTH) + SHEET_AW_W'(xs);

  // Colour lookup for the pixel whose sheet entry has just been read.
  assign col = palette[{rd_data, 3'b000} +: 8];
  assign vis = s1_full && s1_inside && (col != tsb_pkg::TRANSPARENT);

  // A visible pixel pushes the pending one out, which needs a free output slot.
  assign move_ok = !out_valid || out_ready;
  assign stall   = vis && pend_valid && !move_ok;
  assign issue   = (state == ST_SCAN) && !cnt[6] && !stall;

  // Sequencer, scan counter and datapath registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      s1_full    <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_xfer && (in_data.req_type == tsb_pkg::REQ_DRAW)) begin
            state <= ST_SETUP;
          end
        end
        ST_SETUP: begin
          state <= ST_BASE;
        end
        ST_BASE: begin
          state <= ST_SCAN;
        end
        ST_SCAN: begin
          if (cnt[6] && !s1_full) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (!pend_valid) begin
            state <= ST_IDLE;
          end else if (move_ok) begin
            pend_valid <= 1'b0;
            state      <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase

      // Read stage fills on an issue and empties when consumed.
      if (issue) begin
        s1_full <= 1'b1;
      end else if (!stall) begin
        s1_full <= 1'b0;
      end

      if (!stall && vis) begin
        pend_valid <= 1'b1;
      end
    end
  end

  // Payload registers of the datapath.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      x_pos       <= in_data.x_pos;
      y_pos       <= in_data.y_pos;
      tile_index  <= in_data.tile_index;
      palette     <= in_data.palette;
      mirror_bits <= in_data.mirror_bits;
    end
    if (state == ST_SETUP) begin
      ox    <= {{2{x_pos[15]}}, x_pos} - {{2{scroll_x[15]}}, scroll_x};
      oy    <= {{2{y_pos[15]}}, y_pos} - {{2{scroll_y[15]}}, scroll_y};
      w_eff <= (screen_width > 11'(tsb_pkg::MAX_SCREEN_DIM))
               ? 11'(tsb_pkg::MAX_SCREEN_DIM) : screen_width;
      h_eff <= (screen_height > 11'(tsb_pkg::MAX_SCREEN_DIM))
               ? 11'(tsb_pkg::MAX_SCREEN_DIM) : screen_height;
      toffs <= SHEET_AW_W'(32'(tile_index[4:0]) * tsb_pkg::TILE_SIZE)
             + SHEET_AW_W'(32'(tile_index[9:5]) * tsb_pkg::TILE_SIZE
                           * tsb_pkg::SHEET_WIDTH);
    end
    // Row base is the framebuffer address of the tile's top row, modulo 2^20.
    if (state == ST_BASE) begin
      row_base <= 20'({{2{oy[17]}}, oy} * {9'd0, w_eff});
      cnt      <= 7'd0;
    end
    if (issue) begin
      cnt       <= cnt + 7'd1;
      s1_inside <= on_screen;
      s1_addr   <= row_base + {10'd0, sx[9:0]};
      if (px == 3'(tsb_pkg::TILE_SIZE - 1)) begin
        row_base <= row_base + {9'd0, w_eff};
      end
    end
    if (!stall && vis) begin
      pend_addr <= s1_addr;
      pend_col  <= col;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_SCAN && vis && pend_valid && move_ok) begin
      out_valid <= 1'b1;
      out_data  <= '{pixel_address: pend_addr, pixel_colour: pend_col, last_write: 1'b0};
    end else if (state == ST_DRAIN && pend_valid && move_ok) begin
      out_valid <= 1'b1;
      out_data  <= '{pixel_address: pend_addr, pixel_colour: pend_col, last_write: 1'b1};
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

// ===== src/tsb_checker.sv =====
// Port-level checks for the tile sprite blitter, bound to the top level.
// Depends on tsb_pkg and tile_sprite_blitter.
`default_nettype none

module tsb_checker (
  input wire logic          clk,
  input wire logic          rst,
  input wire logic          in_valid,
  input wire logic          in_ready,
  input wire tsb_pkg::req_t in_data,
  input wire logic          out_valid,
  input wire logic          out_ready,
  input wire tsb_pkg::pix_t out_data
);

  // A stalled result transfer keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // A draw transfer makes the block busy on the next cycle.
  a_draw_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (in_data.req_type == tsb_pkg::REQ_DRAW) |=> !in_ready)
    else $error("block ready right after a draw transfer");

  // Transparent pixels are never written.
  a_no_transparent: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.pixel_colour != tsb_pkg::TRANSPARENT)
    else $error("transparent colour written");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind tile_sprite_blitter tsb_checker u_tsb_checker (
  .clk      (clk),
  .rst      (rst),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .in_data  (in_data),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);

`default_nettype wire
